### rtl/hcbd_pkg.sv
// Package with shared types, character codes and a hex helper for the chunked body decoder.
package hcbd_pkg;

    // Width of one body byte and of the size-line digit counter.
    localparam int BYTE_W  = 8;
    localparam int DIGIT_W = 4;

    // Character codes that the parser recognizes.
    localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;

    // One result item as it leaves the parser.
    typedef struct packed {
        logic [BYTE_W-1:0] body_byte;
        logic              body_valid;
        logic              finished;
        logic              failed;
    } hcbd_result_t;

    // Hex digit decode: is_hex tells whether the byte is a digit, value gives its nibble.
    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hcbd_hex_t;

    function automatic hcbd_hex_t hex_decode(input logic [BYTE_W-1:0] b);
        hcbd_hex_t r;
        r.is_hex = 1'b1;
        r.value  = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r.value = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            r.value = 4'(b - 8'h61 + 8'd10);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            r.value = 4'(b - 8'h41 + 8'd10);
        end
        else
        begin
            r.is_hex = 1'b0;
        end
        return r;
    endfunction

endpackage

### rtl/hcbd_if.sv
// Valid/ready channel interfaces for raw input bytes and for decoded result items.
interface hcbd_in_if
    import hcbd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface hcbd_out_if
    import hcbd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] body_byte;
    logic              body_valid;
    logic              finished;
    logic              failed;

    modport source (output valid, output body_byte, output body_valid, output finished,
                    output failed, input ready);
    modport sink   (input valid, input body_byte, input body_valid, input finished,
                    input failed, output ready);
endinterface

### rtl/hcbd_parser.sv
// Parser state machine: phase, remaining chunk length, digit count and trailer flag.
module hcbd_parser
    import hcbd_pkg::*;
#(
    parameter int MAX_SIZE_DIGITS = 15
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] data_byte,
    output hcbd_result_t      result
);

    // The remaining length always keeps 60 bits, whatever the digit limit.
    localparam int LEFT_W = 60;

    localparam logic [3:0] PH_SIZE       = 4'd0;
    localparam logic [3:0] PH_EXT        = 4'd1;
    localparam logic [3:0] PH_SIZE_LF    = 4'd2;
    localparam logic [3:0] PH_DATA       = 4'd3;
    localparam logic [3:0] PH_DATA_CR    = 4'd4;
    localparam logic [3:0] PH_DATA_LF    = 4'd5;
    localparam logic [3:0] PH_TRAILER    = 4'd6;
    localparam logic [3:0] PH_TRAILER_LF = 4'd7;
    localparam logic [3:0] PH_DONE       = 4'd8;
    localparam logic [3:0] PH_ERROR      = 4'd9;

    logic [3:0]         phase_reg, phase_next;
    logic [LEFT_W-1:0]  left_reg, left_next;
    logic [DIGIT_W-1:0] digits_reg, digits_next;
    logic               empty_reg, empty_next;
    hcbd_hex_t          hex;
    logic [LEFT_W-1:0]  left_dec;

    assign hex      = hex_decode(data_byte);
    assign left_dec = left_reg - LEFT_W'(1);

    // Next-state logic for one byte.
    always_comb
    begin
        phase_next        = phase_reg;
        left_next         = left_reg;
        digits_next       = digits_reg;
        empty_next        = empty_reg;
        result.body_byte  = '0;
        result.body_valid = 1'b0;

        unique case (phase_reg)
            PH_SIZE:
            begin
                if (hex.is_hex)
                begin
                    if (digits_reg >= DIGIT_W'(MAX_SIZE_DIGITS))
                    begin
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        digits_next = digits_reg + DIGIT_W'(1);
                        left_next   = {left_reg[LEFT_W-5:0], hex.value};
                    end
                end
                else if (digits_reg == '0)
                begin
                    phase_next = PH_ERROR;
                end
                else if (data_byte == CH_SEMI || data_byte == CH_SP
                         || data_byte == CH_TAB)
                begin
                    phase_next = PH_EXT;
                end
                else if (data_byte == CH_CR)
                begin
                    phase_next = PH_SIZE_LF;
                end
                else if (data_byte == CH_LF)
                begin
                    if (left_reg == '0)
                    begin
                        phase_next = PH_TRAILER;
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            PH_EXT, PH_SIZE_LF:
            begin
                if (data_byte == CH_LF)
                begin
                    if (left_reg == '0)
                    begin
                        phase_next = PH_TRAILER;
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                else if (phase_reg == PH_SIZE_LF)
                begin
                    phase_next = PH_ERROR;
                end
                else if (data_byte == CH_CR)
                begin
                    phase_next = PH_SIZE_LF;
                end
            end
            PH_DATA:
            begin
                result.body_byte  = data_byte;
                result.body_valid = 1'b1;
                left_next         = left_dec;
                if (left_dec == '0)
                begin
                    phase_next = PH_DATA_CR;
                end
            end
            PH_DATA_CR, PH_DATA_LF:
            begin
                if (data_byte == CH_CR && phase_reg == PH_DATA_CR)
                begin
                    phase_next = PH_DATA_LF;
                end
                else if (data_byte == CH_LF)
                begin
                    phase_next  = PH_SIZE;
                    left_next   = '0;
                    digits_next = '0;
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            PH_TRAILER, PH_TRAILER_LF:
            begin
                if (data_byte == CH_LF)
                begin
                    // An empty line ends the trailer; otherwise a new line starts.
                    if (empty_reg)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_TRAILER;
                        empty_next = 1'b1;
                    end
                end
                else if (phase_reg == PH_TRAILER_LF)
                begin
                    phase_next = PH_ERROR;
                end
                else if (data_byte == CH_CR)
                begin
                    phase_next = PH_TRAILER_LF;
                end
                else
                begin
                    empty_next = 1'b0;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase

        result.finished = (phase_next == PH_DONE);
        result.failed   = (phase_next == PH_ERROR);
    end

    // State registers advance once per byte handed in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIZE;
            left_reg   <= '0;
            digits_reg <= '0;
            empty_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            digits_reg <= digits_next;
            empty_reg  <= empty_next;
        end
    end

endmodule

### rtl/http_chunked_body_decoder.sv
// Top level of the chunked body decoder: input register, parser and result register.
// A byte goes to the input register, then its result item to the result register.
// Throughput: one byte per cycle while the sink keeps up; one parser step per byte.
// The result register frees while a result waits only when the sink takes it.
// Reset (rst_n, asynchronous, active low) empties both registers and returns the
// parser to the start of a size line with zero length and digit count.
module http_chunked_body_decoder
    import hcbd_pkg::*;
#(
    parameter int MAX_SIZE_DIGITS = 15
)
(
    input logic          clk,
    input logic          rst_n,
    hcbd_in_if.sink      byte_ch,
    hcbd_out_if.source   result_ch
);

    logic              s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              out_valid_reg, out_valid_next;
    hcbd_result_t      res_reg;
    hcbd_result_t      parse_res;
    logic              out_free;
    logic              s1_fire;
    logic              in_fire;

    // Handshake: the input register moves on when the result register can load.
    assign out_free      = !out_valid_reg || result_ch.ready;
    assign s1_fire       = s1_valid_reg && out_free;
    assign byte_ch.ready = !s1_valid_reg || s1_fire;
    assign in_fire       = byte_ch.valid && byte_ch.ready;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !s1_fire);
    assign out_valid_next = s1_fire || (out_valid_reg && !result_ch.ready);

    hcbd_parser #(
        .MAX_SIZE_DIGITS(MAX_SIZE_DIGITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_fire),
        .data_byte (s1_byte_reg),
        .result    (parse_res)
    );

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= byte_ch.data_byte;
        end
        if (s1_fire)
        begin
            res_reg <= parse_res;
        end
    end

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.body_byte  = res_reg.body_byte;
    assign result_ch.body_valid = res_reg.body_valid;
    assign result_ch.finished   = res_reg.finished;
    assign result_ch.failed     = res_reg.failed;

    // A result item is never both finished and failed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.finished && res_reg.failed))
        else $error("result item both finished and failed");

    // Payload bytes only come before the body ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.body_valid) |-> (!res_reg.finished && !res_reg.failed))
        else $error("payload byte flagged after end of body");

    // Once an error is reported, every later result item reports it too.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.failed) |=> (!out_valid_reg || res_reg.failed))
        else $error("error flag dropped");

    // The input side stalls only while a byte waits in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ch.ready |-> (s1_valid_reg && out_valid_reg && !result_ch.ready))
        else $error("input stalled without a waiting item");

endmodule
